[rtl/mfpr_pkg.sv]
package mfpr_pkg;

   // Frame markers and register reset values
   localparam logic [7:0]  MARK_START        = 8'h68;
   localparam logic [7:0]  MARK_END          = 8'h16;
   localparam logic [15:0] TIMEOUT_RESET     = 16'd5000;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'hFFFF;

   // Configuration register indexes
   localparam int          CSR_INDEX_W      = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_MS  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD = 1'b1;

   // Request word modes
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // Response word kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   // End-of-frame status codes
   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_BAD_MARKER = 3'd1;
   localparam logic [2:0] STAT_CHECKSUM   = 3'd2;
   localparam logic [2:0] STAT_BAD_END    = 3'd3;
   localparam logic [2:0] STAT_TIMEOUT    = 3'd4;
   localparam logic [2:0] STAT_NULL_CMD   = 3'd5;
   localparam logic [2:0] STAT_TOO_LONG   = 3'd6;

   // Live configuration
   typedef struct packed {
      logic [15:0] timeout_ms;
      logic [15:0] max_payload;
   } cfg_type;

   // One result word plus its valid flag
   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [7:0]  payload_byte;
      logic [7:0]  command;
      logic [15:0] payload_length;
      logic [2:0]  status;
   } result_type;

endpackage

[rtl/mfpr_req_if.sv]
interface mfpr_req_if import mfpr_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

[rtl/mfpr_rsp_if.sv]
interface mfpr_rsp_if import mfpr_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  payload_byte;
   logic [7:0]  command;
   logic [15:0] payload_length;
   logic [2:0]  status;

   modport source (output valid, output kind, output payload_byte, output command,
                   output payload_length, output status, input ready);
   modport sink   (input valid, input kind, input payload_byte, input command,
                   input payload_length, input status, output ready);
endinterface

[rtl/mfpr_csr_if.sv]
interface mfpr_csr_if import mfpr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [15:0]            data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/mfpr_csr_regs.sv]
module mfpr_csr_regs import mfpr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mfpr_csr_if.sink    csr,
   output cfg_type     cfg
);

   logic [15:0] timeout_ms_ff, timeout_ms_in;
   logic [15:0] max_payload_ff, max_payload_in;

   // Always able to take a write word
   assign csr.ready = 1'b1;

   // Register write decode
   always_comb begin
      timeout_ms_in  = timeout_ms_ff;
      max_payload_in = max_payload_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_TIMEOUT_MS:  timeout_ms_in  = csr.data;
            CSR_MAX_PAYLOAD: max_payload_in = csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ms_ff  <= TIMEOUT_RESET;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         timeout_ms_ff  <= timeout_ms_in;
         max_payload_ff <= max_payload_in;
      end
   end

   assign cfg.timeout_ms  = timeout_ms_ff;
   assign cfg.max_payload = max_payload_ff;

endmodule

[rtl/mfpr_frame_engine.sv]
module mfpr_frame_engine import mfpr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mfpr_req_if.sink    req,
   input  cfg_type     cfg,
   input  logic        out_free,
   output result_type  result
);

   // Frame phases
   localparam logic [2:0] PH_HEADER   = 3'd0;
   localparam logic [2:0] PH_PAYLOAD  = 3'd1;
   localparam logic [2:0] PH_CHECKSUM = 3'd2;
   localparam logic [2:0] PH_END      = 3'd3;

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic       mode_ff;
   logic [7:0] byte_ff;
   logic       advance;

   // Frame state
   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  hidx_ff, hidx_in;
   logic        marker_bad_ff, marker_bad_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  command_ff, command_in;
   logic [15:0] seen_ff, seen_in;
   logic [7:0]  xor_ff, xor_in;
   logic [15:0] elapsed_ff, elapsed_in;

   // Word in the input register moves on when the output slot can take it
   assign advance     = in_valid_ff && out_free;
   assign req.ready   = !in_valid_ff || advance;
   assign in_valid_in = req.valid ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         mode_ff <= req.mode;
         byte_ff <= req.data_byte;
      end
   end

   // One step of the receiver for the registered word
   always_comb begin
      logic [2:0]  ph;
      logic [2:0]  hi;
      logic        active;
      logic [15:0] el;
      logic        end_now;
      logic [2:0]  stat;

      // unreachable phase codes fall back to idle
      ph     = (phase_ff > PH_END) ? PH_HEADER : phase_ff;
      hi     = (phase_ff > PH_END) ? 3'd0 : hidx_ff;
      active = !(ph == PH_HEADER && hi == 3'd0);

      phase_in      = ph;
      hidx_in       = hi;
      marker_bad_in = marker_bad_ff;
      length_in     = length_ff;
      command_in    = command_ff;
      seen_in       = seen_ff;
      xor_in        = xor_ff;
      elapsed_in    = elapsed_ff;
      el            = elapsed_ff;
      end_now       = 1'b0;
      stat          = STAT_OK;

      result.valid        = 1'b0;
      result.kind         = KIND_PAYLOAD;
      result.payload_byte = 8'd0;

      if (mode_ff == MODE_TICK) begin
         if (active) begin
            el         = (elapsed_ff != 16'hFFFF) ? elapsed_ff + 16'd1 : elapsed_ff;
            elapsed_in = el;
            if (el >= cfg.timeout_ms) begin
               end_now = 1'b1;
               stat    = STAT_TIMEOUT;
            end
         end
      end else begin
         unique case (ph)
            PH_HEADER: begin
               // first byte opens a fresh frame
               if (hi == 3'd0) begin
                  marker_bad_in = 1'b0;
                  length_in     = 16'd0;
                  command_in    = 8'd0;
                  seen_in       = 16'd0;
                  xor_in        = 8'd0;
                  elapsed_in    = 16'd0;
               end
               case (hi) inside
                  3'd0, 3'd3: if (byte_ff != MARK_START) marker_bad_in = 1'b1;
                  3'd1:       length_in = {length_in[15:8], byte_ff};
                  3'd2:       length_in = {byte_ff, length_in[7:0]};
                  default:    command_in = byte_ff;
               endcase
               if (hi < 3'd4) begin
                  hidx_in = hi + 3'd1;
               end else begin
                  hidx_in = 3'd0;
                  if (marker_bad_in) begin
                     end_now = 1'b1;
                     stat    = STAT_BAD_MARKER;
                  end else if (length_in > cfg.max_payload) begin
                     end_now = 1'b1;
                     stat    = STAT_TOO_LONG;
                  end else begin
                     phase_in = (length_in == 16'd0) ? PH_CHECKSUM : PH_PAYLOAD;
                     hidx_in  = 3'd1;   // keeps the frame marked busy
                  end
               end
            end
            PH_PAYLOAD: begin
               xor_in  = xor_ff ^ byte_ff;
               seen_in = seen_ff + 16'd1;
               if (seen_in >= length_ff) phase_in = PH_CHECKSUM;
               result.valid        = 1'b1;
               result.payload_byte = byte_ff;
            end
            PH_CHECKSUM: begin
               xor_in   = xor_ff ^ byte_ff;
               phase_in = PH_END;
            end
            default: begin
               end_now = 1'b1;
               if (xor_ff != 8'd0)          stat = STAT_CHECKSUM;
               else if (byte_ff != MARK_END) stat = STAT_BAD_END;
               else if (command_ff == 8'd0) stat = STAT_NULL_CMD;
               else                         stat = STAT_OK;
            end
         endcase
      end

      // frame end returns to idle
      if (end_now) begin
         phase_in            = PH_HEADER;
         hidx_in             = 3'd0;
         result.valid        = 1'b1;
         result.kind         = KIND_END;
         result.payload_byte = 8'd0;
      end

      result.valid          = result.valid && advance;
      result.command        = command_in;
      result.payload_length = length_in;
      result.status         = stat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         hidx_ff       <= 3'd0;
         marker_bad_ff <= 1'b0;
         length_ff     <= 16'd0;
         command_ff    <= 8'd0;
         seen_ff       <= 16'd0;
         xor_ff        <= 8'd0;
         elapsed_ff    <= 16'd0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         hidx_ff       <= hidx_in;
         marker_bad_ff <= marker_bad_in;
         length_ff     <= length_in;
         command_ff    <= command_in;
         seen_ff       <= seen_in;
         xor_ff        <= xor_in;
         elapsed_ff    <= elapsed_in;
      end
   end

endmodule

[rtl/mfpr_out_reg.sv]
module mfpr_out_reg import mfpr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  result_type  result,
   output logic        out_free,
   mfpr_rsp_if.source  rsp
);

   logic        valid_ff, valid_in;
   result_type  word_ff;

   // Slot is free when empty or being drained this cycle
   assign out_free = !valid_ff || rsp.ready;
   assign valid_in = result.valid ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         word_ff <= result;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.kind           = word_ff.kind;
   assign rsp.payload_byte   = word_ff.payload_byte;
   assign rsp.command        = word_ff.command;
   assign rsp.payload_length = word_ff.payload_length;
   assign rsp.status         = word_ff.status;

endmodule

[rtl/marker_framed_packet_receiver_core.sv]
// Marker framed packet receiver: one request word (byte or ms tick) per cycle.
// Path: a request word is taken into the input register, and its result word, if any,
// is made by the frame step and registered in the output register.
// Throughput: one word per cycle, limited only by the output register draining.
// Reset: synchronous, active high; receiver idle, timeout 5000, max payload 65535.
module marker_framed_packet_receiver_core import mfpr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mfpr_req_if.sink    req_ch,
   mfpr_rsp_if.source  rsp_ch,
   mfpr_csr_if.sink    csr_ch
);

   cfg_type    cfg;
   result_type result;
   logic       out_free;

   // Configuration registers
   mfpr_csr_regs u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   // Input register and frame step
   mfpr_frame_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .cfg      (cfg),
      .out_free (out_free),
      .result   (result)
   );

   // Result register
   mfpr_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .out_free (out_free),
      .rsp      (rsp_ch)
   );

endmodule
